### hw/rtl/cartridge_bank_mapper_defines.svh
// Assertion macros shared by the cartridge bank mapper RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef CARTRIDGE_BANK_MAPPER_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CBM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/cbm_pkg.sv
// Shared types and constants of the cartridge bank mapper.
// No dependencies; used by cbm_bank_ctrl and cartridge_bank_mapper.
`timescale 1ns / 1ps

package cbm_pkg;

  localparam int unsigned PAGE_W     = 12;  // 4 KiB address pages
  localparam int unsigned ROM_PAGE_W = 7;   // ROM page number, up to 512 KiB
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned LG_W       = 3;
  localparam int unsigned CFG_DATA_W = 3;
  localparam int unsigned OFFSET_W   = 19;

  localparam logic [2:0] RAM_WINDOW = 3'd3;     // address[15:13] of 0x6000-0x7FFF
  localparam logic [4:0] CTRL_RESET = 5'h0C;    // MMC1 control after a reset write
  localparam logic [2:0] SHIFT_LEN  = 3'd5;     // serial writes per register load
  localparam logic [LG_W-1:0] ROM_LG_MAX = 3'd5;

  typedef enum logic [KIND_W-1:0] {
    KIND_NROM  = 3'd0,
    KIND_CNROM = 3'd1,
    KIND_MMC1  = 3'd2,
    KIND_AXROM = 3'd3
  } cbm_kind_e;

  typedef enum logic [0:0] {
    CFG_MAPPER_KIND = 1'b0,
    CFG_ROM_SIZE    = 1'b1
  } cbm_cfg_idx_e;

  typedef enum logic {
    MODE_READ  = 1'b0,
    MODE_WRITE = 1'b1
  } cbm_mode_e;

  // Bus transaction handed from the input register to the bank logic.
  typedef struct packed {
    logic        fire;
    logic        mode;
    logic [15:0] address;
    logic [7:0]  write_data;
  } cbm_req_t;

  // Configuration view seen by the bank logic.
  typedef struct packed {
    logic              init;
    logic [KIND_W-1:0] init_kind;
    logic [KIND_W-1:0] kind;
  } cbm_ctl_t;

  // Bank logic answer for the current transaction.
  typedef struct packed {
    logic [ROM_PAGE_W-1:0] rom_page;
    logic                  ram_disable;
    logic                  write_ignored;
  } cbm_rsp_t;

endpackage

### hw/rtl/cbm_bank_ctrl.sv
// Bank state of the mapper: page table of the 0x8000-0xFFFF half, MMC1 serial port.
// Depends on cbm_pkg and cartridge_bank_mapper_defines.svh.
`timescale 1ns / 1ps
`include "cartridge_bank_mapper_defines.svh"

module cbm_bank_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cbm_pkg::cbm_req_t req_i,
  input  cbm_pkg::cbm_ctl_t ctl_i,
  output cbm_pkg::cbm_rsp_t rsp_o
);

  typedef logic [cbm_pkg::ROM_PAGE_W-1:0] rom_page_t;

  // Power-on / reconfigure mapping of upper page k (0x8000 + k * 4 KiB).
  function automatic rom_page_t init_entry(input logic [2:0] kind, input logic [2:0] k);
    if (kind == cbm_pkg::KIND_NROM || kind == cbm_pkg::KIND_CNROM) begin
      return {4'd0, k};
    end else if (!k[2]) begin
      return {5'd0, k[1:0]};
    end else begin
      return {5'h1F, k[1:0]};
    end
  endfunction

  // MMC1 PRG mapping of upper page k from control and PRG bank registers.
  function automatic rom_page_t mmc1_entry(input logic [4:0] ctrl, input logic [4:0] prg,
                                           input logic [2:0] k);
    if (!ctrl[3]) begin
      return {1'b0, prg[3:1], k};
    end else if (!ctrl[2]) begin
      return k[2] ? {1'b0, prg[3:0], k[1:0]} : {5'd0, k[1:0]};
    end else begin
      return k[2] ? {5'h1F, k[1:0]} : {1'b0, prg[3:0], k[1:0]};
    end
  endfunction

  rom_page_t  upper_q [8];
  rom_page_t  upper_d [8];
  logic [4:0] shift_value_q, shift_value_d;
  logic [2:0] shift_count_q, shift_count_d;
  logic [4:0] ctrl_q, ctrl_d;
  logic [4:0] prg_q, prg_d;
  logic       ram_dis_q, ram_dis_d;

  logic       bank_wr;
  logic       mmc1_wr;
  logic       axrom_wr;
  logic       remap;
  logic [4:0] shift_next;
  logic [2:0] count_next;
  logic [3:0] page;
  rom_page_t  low_entry;

  always_comb begin
    bank_wr  = (req_i.mode == cbm_pkg::MODE_WRITE) && req_i.address[15];
    mmc1_wr  = req_i.fire && bank_wr && (ctl_i.kind == cbm_pkg::KIND_MMC1);
    axrom_wr = req_i.fire && bank_wr && (ctl_i.kind == cbm_pkg::KIND_AXROM);

    shift_next = shift_value_q | (5'(req_i.write_data[0]) << shift_count_q);
    count_next = 3'(shift_count_q + 3'd1);

    shift_value_d = shift_value_q;
    shift_count_d = shift_count_q;
    ctrl_d        = ctrl_q;
    prg_d         = prg_q;
    remap         = 1'b0;

    if (mmc1_wr) begin
      if (req_i.write_data[7]) begin
        shift_value_d = '0;
        shift_count_d = '0;
        ctrl_d        = cbm_pkg::CTRL_RESET;
        remap         = 1'b1;
      end else if (count_next >= cbm_pkg::SHIFT_LEN) begin
        // Registers 1 and 2 are CHR banks and are not kept.
        if (req_i.address[14:13] == 2'd0) begin
          ctrl_d = shift_next;
        end
        if (req_i.address[14:13] == 2'd3) begin
          prg_d = shift_next;
        end
        shift_value_d = '0;
        shift_count_d = '0;
        remap         = 1'b1;
      end else begin
        shift_value_d = shift_next;
        shift_count_d = count_next;
      end
    end

    ram_dis_d = remap ? prg_d[4] : ram_dis_q;

    for (int k = 0; k < 8; k++) begin
      if (ctl_i.init) begin
        upper_d[k] = init_entry(ctl_i.init_kind, 3'(k));
      end else if (remap) begin
        upper_d[k] = mmc1_entry(ctrl_d, prg_d, 3'(k));
      end else if (axrom_wr) begin
        upper_d[k] = {1'b0, req_i.write_data[2:0], 3'(k)};
      end else begin
        upper_d[k] = upper_q[k];
      end
    end
  end

  // Lower half never changes after a table init: zero for 32 KiB boards,
  // bank 0 repeated for the others.
  always_comb begin
    page = req_i.address[15:12];
    if (ctl_i.kind == cbm_pkg::KIND_NROM || ctl_i.kind == cbm_pkg::KIND_CNROM) begin
      low_entry = '0;
    end else begin
      low_entry = {5'd0, page[1:0]};
    end
    rsp_o.rom_page      = page[3] ? upper_q[page[2:0]] : low_entry;
    rsp_o.ram_disable   = ram_dis_d;
    rsp_o.write_ignored = (req_i.mode == cbm_pkg::MODE_WRITE) &&
                          !(req_i.address[15] && (ctl_i.kind == cbm_pkg::KIND_MMC1 ||
                                                  ctl_i.kind == cbm_pkg::KIND_AXROM));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 8; k++) begin
        upper_q[k] <= init_entry(cbm_pkg::KIND_NROM, 3'(k));
      end
      shift_value_q <= '0;
      shift_count_q <= '0;
      ctrl_q        <= '0;
      prg_q         <= '0;
      ram_dis_q     <= 1'b0;
    end else begin
      for (int k = 0; k < 8; k++) begin
        upper_q[k] <= upper_d[k];
      end
      shift_value_q <= shift_value_d;
      shift_count_q <= shift_count_d;
      ctrl_q        <= ctrl_d;
      prg_q         <= prg_d;
      ram_dis_q     <= ram_dis_d;
    end
  end

  `CBM_ASSERT_IMPL(a_shift_count_bound, 1'b1, shift_count_q < cbm_pkg::SHIFT_LEN, "shift count overran")
  `CBM_ASSERT_NEXT(a_mmc1_reset_write, mmc1_wr && req_i.write_data[7], ctrl_q == cbm_pkg::CTRL_RESET && shift_count_q == 3'd0, "reset write did not restore control")
  `CBM_ASSERT_IMPL(a_ram_dis_hold, !remap, ram_dis_d == ram_dis_q, "ram disable moved without remap")

endmodule

### hw/rtl/cartridge_bank_mapper.sv
// Top level of the cartridge program-memory mapper: handshake, config and offset path.
// Depends on cbm_pkg, cbm_bank_ctrl and cartridge_bank_mapper_defines.svh.
`timescale 1ns / 1ps
`include "cartridge_bank_mapper_defines.svh"

// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one CPU bus transaction:
//   mode, address and write data. Output channel (out_valid_o / out_stall_i)
//   returns exactly one result per transaction, in order.
//   Reads of 0x6000-0x7FFF flag ram_hit with the RAM offset; other reads give
//   the ROM byte offset through the bank mapping. Writes drive MMC1 or AxROM
//   bank selection, or come back with write_ignored set.
//   Throughput: one transaction per cycle while the receiver does not
//   stall. A transaction waits in the input register and then lands in the
//   result register; the bank table lookup plus the offset assembly sit
//   between those two registers, and a write updates the bank state as it
//   enters the result register, so the next transaction already sees the
//   new mapping. Reset: mapper_kind 0 (NROM), rom_size_log2 1 (32 KiB),
//   serial port and RAM disable cleared, both channels empty. Config writes
//   (cfg_we_i) rebuild the page table; the user must make them only while
//   no transaction is in flight, which the block does not enforce.
//   Receiver stall: the result register holds; a transaction already in the
//   input register waits, and in_stall_o rises only then.
module cartridge_bank_mapper (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [0:0]                       cfg_index_i,
  input  logic [cbm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // bus transaction in
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             in_mode_i,
  input  logic [15:0]                      in_address_i,
  input  logic [7:0]                       in_write_data_i,
  // result out
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             out_ram_hit_o,
  output logic [cbm_pkg::OFFSET_W-1:0]     out_mem_offset_o,
  output logic                             out_ram_disabled_o,
  output logic                             out_write_ignored_o
);

  typedef logic [cbm_pkg::ROM_PAGE_W-1:0] rom_page_t;

  // Page-number mask for a ROM of 16 KiB << lg; sizes above 512 KiB clamp.
  function automatic rom_page_t rom_page_mask(input logic [cbm_pkg::LG_W-1:0] lg);
    logic [cbm_pkg::LG_W-1:0] lgc;
    lgc = (lg > cbm_pkg::ROM_LG_MAX) ? cbm_pkg::ROM_LG_MAX : lg;
    return cbm_pkg::ROM_PAGE_W'((8'd4 << lgc) - 8'd1);
  endfunction

  // Configuration registers
  logic [cbm_pkg::KIND_W-1:0] kind_q, kind_d;
  logic [cbm_pkg::LG_W-1:0]   lg_q, lg_d;

  // Input register
  logic        in_valid_q, in_valid_d;
  logic        in_mode_q;
  logic [15:0] in_address_q;
  logic [7:0]  in_write_data_q;

  // Result register
  logic                         out_valid_q, out_valid_d;
  logic                         out_ram_hit_q, res_ram_hit;
  logic [cbm_pkg::OFFSET_W-1:0] out_mem_offset_q, res_mem_offset;
  logic                         out_ram_disabled_q;
  logic                         out_write_ignored_q;

  logic              out_free;
  logic              fire;
  logic              in_accept;
  cbm_pkg::cbm_req_t req;
  cbm_pkg::cbm_ctl_t ctl;
  cbm_pkg::cbm_rsp_t rsp;

  // Handshake: advance the input register whenever the result register can
  // take its transaction this cycle.
  always_comb begin
    out_free    = !out_valid_q || !out_stall_i;
    fire        = in_valid_q && out_free;
    in_stall_o  = in_valid_q && !out_free;
    in_accept   = in_valid_i && !in_stall_o;
    in_valid_d  = in_accept || (in_valid_q && !fire);
    out_valid_d = fire || (out_valid_q && !out_free);
  end

  // Config decode; any write rebuilds the table from the new kind.
  always_comb begin
    kind_d = kind_q;
    lg_d   = lg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        cbm_pkg::CFG_MAPPER_KIND: kind_d = cfg_data_i;
        cbm_pkg::CFG_ROM_SIZE:    lg_d   = cfg_data_i;
        default:                  kind_d = kind_q;
      endcase
    end
  end

  always_comb begin
    req.fire       = fire;
    req.mode       = in_mode_q;
    req.address    = in_address_q;
    req.write_data = in_write_data_q;
    ctl.init       = cfg_we_i;
    ctl.init_kind  = kind_d;
    ctl.kind       = kind_q;
  end

  cbm_bank_ctrl u_bank_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .ctl_i  (ctl),
    .rsp_o  (rsp)
  );

  // Offset path: RAM window passes address bits through, ROM reads splice
  // the masked ROM page onto the in-page offset. Writes report zero.
  always_comb begin
    res_ram_hit    = 1'b0;
    res_mem_offset = '0;
    if (in_mode_q == cbm_pkg::MODE_READ) begin
      if (in_address_q[15:13] == cbm_pkg::RAM_WINDOW) begin
        res_ram_hit    = 1'b1;
        res_mem_offset = {6'd0, in_address_q[12:0]};
      end else begin
        res_mem_offset = {rsp.rom_page & rom_page_mask(lg_q),
                          in_address_q[cbm_pkg::PAGE_W-1:0]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= cbm_pkg::KIND_NROM;
      lg_q        <= 3'd1;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      kind_q      <= kind_d;
      lg_q        <= lg_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on transfer, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_mode_q       <= in_mode_i;
      in_address_q    <= in_address_i;
      in_write_data_q <= in_write_data_i;
    end
    if (fire) begin
      out_ram_hit_q       <= res_ram_hit;
      out_mem_offset_q    <= res_mem_offset;
      out_ram_disabled_q  <= rsp.ram_disable;
      out_write_ignored_q <= rsp.write_ignored;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_ram_hit_o       = out_ram_hit_q;
  assign out_mem_offset_o    = out_mem_offset_q;
  assign out_ram_disabled_o  = out_ram_disabled_q;
  assign out_write_ignored_o = out_write_ignored_q;

  `CBM_ASSERT_NEXT(a_pending_held, in_valid_q && !fire, in_valid_q, "pending transaction dropped")
  `CBM_ASSERT_NEXT(a_fire_to_result, fire, out_valid_q, "processed transaction lost")
  `CBM_ASSERT_IMPL(a_stall_cause, in_stall_o, out_valid_q && out_stall_i, "input stalled without backpressure")

endmodule
